>>> rtl/cbp_pkg.sv
// Shared widths, constants and types of the cubic Bezier proximity pipeline.
`timescale 1ns / 1ps
package cbp_pkg;

  localparam int CHORD_COUNT_DEF = 10;

  localparam int COORD_W   = 16;  // Q12.4 input coordinate
  localparam int WEIGHT_W  = 17;  // Q1.16 Bernstein weight, 1.0 included
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = COORD_W + WEIGHT_W + 1;
  localparam int SUM_W     = PROD_W + 2;
  localparam int SAMP_W    = 18;  // Q.4 sample point
  localparam int DIFF_W    = SAMP_W + 1;
  localparam int SQ_W      = 2 * DIFF_W;      // one signed square or product
  localparam int LEN_W     = SQ_W;            // squared chord length, unsigned
  localparam int DOT_W     = SQ_W + 1;
  localparam int T_W       = FRAC_BITS + 1;   // projection parameter 0..1.0
  localparam int DEN_W     = LEN_W + 1;
  localparam int NUM_W     = DOT_W + T_W;
  localparam int PT_W      = T_W + 1 + DIFF_W;
  localparam int OFF_W     = DIFF_W + 2;
  localparam int OSQ_W     = 2 * OFF_W;
  localparam int DIST_W    = OSQ_W + 1;
  localparam int NEAR_W    = 12;
  localparam int THR_W     = 2 * NEAR_W;

  localparam logic [NEAR_W-1:0] NEAR_RESET = NEAR_W'(80);
  localparam logic [T_W-1:0]    T_ONE      = T_W'(1) << FRAC_BITS;

  // Cycle counts of the two pipeline sections.
  localparam int SAMP_LAT = 2;
  localparam int DIV_LAT  = T_W;
  localparam int LANE_LAT = 4 + DIV_LAT + 4;

  typedef enum logic [1:0] {
    PM_ZERO,
    PM_ONE,
    PM_DIV
  } proj_mode_t;

  typedef struct packed {
    proj_mode_t                mode;
    logic signed [DIFF_W-1:0]  rx;
    logic signed [DIFF_W-1:0]  ry;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
  } chord_side_t;

endpackage

>>> rtl/cbp_sample.sv
// Curve sampling: Bernstein weighted sums giving the chord end points.
`timescale 1ns / 1ps
module cbp_sample
  import cbp_pkg::*;
#(
  parameter int CHORD_COUNT = CHORD_COUNT_DEF
) (
  input  logic                      clk,
  input  logic                      adv,
  input  logic signed [COORD_W-1:0] qx,
  input  logic signed [COORD_W-1:0] qy,
  input  logic signed [COORD_W-1:0] px [4],
  input  logic signed [COORD_W-1:0] py [4],
  output logic signed [COORD_W-1:0] qx_o,
  output logic signed [COORD_W-1:0] qy_o,
  output logic signed [SAMP_W-1:0]  samp_x [CHORD_COUNT+1],
  output logic signed [SAMP_W-1:0]  samp_y [CHORD_COUNT+1]
);

  localparam longint NC = CHORD_COUNT;
  localparam longint N3 = NC * NC * NC;

  logic signed [COORD_W-1:0] q1x_r, q1y_r, q2x_r, q2y_r;
  logic signed [COORD_W-1:0] s1x_r, s1y_r;
  logic signed [SAMP_W-1:0]  s2x_r, s2y_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      q1x_r <= qx;
      q1y_r <= qy;
      q2x_r <= q1x_r;
      q2y_r <= q1y_r;
      s1x_r <= px[0];
      s1y_r <= py[0];
      s2x_r <= SAMP_W'(s1x_r);
      s2y_r <= SAMP_W'(s1y_r);
    end
  end

  assign qx_o      = q2x_r;
  assign qy_o      = q2y_r;
  assign samp_x[0] = s2x_r;
  assign samp_y[0] = s2y_r;

  for (genvar i = 1; i <= CHORD_COUNT; i++) begin : g_samp
    localparam longint IV = i;
    localparam longint KV = NC - IV;
    localparam longint W1 = (KV * KV * KV * 131072 + N3) / (2 * N3);
    localparam longint W2 = (3 * KV * KV * IV * 131072 + N3) / (2 * N3);
    localparam longint W3 = (3 * KV * IV * IV * 131072 + N3) / (2 * N3);
    localparam longint W4 = (IV * IV * IV * 131072 + N3) / (2 * N3);
    localparam logic [WEIGHT_W-1:0] WV [4] = '{WEIGHT_W'(W1), WEIGHT_W'(W2),
                                               WEIGHT_W'(W3), WEIGHT_W'(W4)};

    logic signed [PROD_W-1:0] prx_r [4];
    logic signed [PROD_W-1:0] pry_r [4];
    logic signed [SUM_W-1:0]  sumx, sumy;
    logic signed [SAMP_W-1:0] cx_r, cy_r;

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int j = 0; j < 4; j++) begin
          prx_r[j] <= $signed({1'b0, WV[j]}) * px[j];
          pry_r[j] <= $signed({1'b0, WV[j]}) * py[j];
        end
      end
    end

    // Round to nearest with halves going up, then drop the weight fraction.
    always_comb begin
      sumx = SUM_W'(prx_r[0]) + SUM_W'(prx_r[1]) + SUM_W'(prx_r[2])
           + SUM_W'(prx_r[3]) + SUM_W'(32768);
      sumy = SUM_W'(pry_r[0]) + SUM_W'(pry_r[1]) + SUM_W'(pry_r[2])
           + SUM_W'(pry_r[3]) + SUM_W'(32768);
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        cx_r <= sumx[FRAC_BITS+SAMP_W-1:FRAC_BITS];
        cy_r <= sumy[FRAC_BITS+SAMP_W-1:FRAC_BITS];
      end
    end

    assign samp_x[i] = cx_r;
    assign samp_y[i] = cy_r;
  end

endmodule

>>> rtl/cbp_div.sv
// Pipelined restoring divider for the projection parameter, one bit a stage.
`timescale 1ns / 1ps
module cbp_div
  import cbp_pkg::*;
(
  input  logic             clk,
  input  logic             adv,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [T_W-1:0]   quo
);

  logic [NUM_W-1:0] rem_r [DIV_LAT];
  logic [DEN_W-1:0] den_r [DIV_LAT];
  logic [T_W-1:0]   quo_r [DIV_LAT];
  logic [NUM_W-1:0] rem_nxt [DIV_LAT];
  logic [T_W-1:0]   quo_nxt [DIV_LAT];

  always_comb begin
    logic [NUM_W-1:0] rin;
    logic [NUM_W-1:0] sh;
    logic [DEN_W-1:0] din;
    logic [T_W-1:0]   qin;
    for (int s = 0; s < DIV_LAT; s++) begin
      rin = (s == 0) ? num : rem_r[(s == 0) ? 0 : s - 1];
      din = (s == 0) ? den : den_r[(s == 0) ? 0 : s - 1];
      qin = (s == 0) ? '0  : quo_r[(s == 0) ? 0 : s - 1];
      sh  = NUM_W'(din) << (DIV_LAT - 1 - s);
      if (rin >= sh) begin
        rem_nxt[s] = rin - sh;
        quo_nxt[s] = qin | (T_W'(1) << (DIV_LAT - 1 - s));
      end else begin
        rem_nxt[s] = rin;
        quo_nxt[s] = qin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < DIV_LAT; s++) begin
        rem_r[s] <= rem_nxt[s];
        quo_r[s] <= quo_nxt[s];
        den_r[s] <= (s == 0) ? den : den_r[(s == 0) ? 0 : s - 1];
      end
    end
  end

  assign quo = quo_r[DIV_LAT-1];

endmodule

>>> rtl/cbp_chord.sv
// One chord lane: projection of the query point and the distance test.
`timescale 1ns / 1ps
module cbp_chord
  import cbp_pkg::*;
(
  input  logic                      clk,
  input  logic                      adv,
  input  logic [THR_W-1:0]          thr2,
  input  logic signed [COORD_W-1:0] qx,
  input  logic signed [COORD_W-1:0] qy,
  input  logic signed [SAMP_W-1:0]  sx,
  input  logic signed [SAMP_W-1:0]  sy,
  input  logic signed [SAMP_W-1:0]  ex,
  input  logic signed [SAMP_W-1:0]  ey,
  output logic                      hit
);

  // Offsets from the chord start.
  logic signed [DIFF_W-1:0] dx1_r, dy1_r, rx1_r, ry1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      dx1_r <= DIFF_W'(ex) - DIFF_W'(sx);
      dy1_r <= DIFF_W'(ey) - DIFF_W'(sy);
      rx1_r <= DIFF_W'(qx) - DIFF_W'(sx);
      ry1_r <= DIFF_W'(qy) - DIFF_W'(sy);
    end
  end

  logic signed [SQ_W-1:0]   dxx_r, dyy_r, rdx_r, rdy_r;
  logic signed [DIFF_W-1:0] dx2_r, dy2_r, rx2_r, ry2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      dxx_r <= dx1_r * dx1_r;
      dyy_r <= dy1_r * dy1_r;
      rdx_r <= rx1_r * dx1_r;
      rdy_r <= ry1_r * dy1_r;
      dx2_r <= dx1_r;
      dy2_r <= dy1_r;
      rx2_r <= rx1_r;
      ry2_r <= ry1_r;
    end
  end

  logic signed [DOT_W-1:0]  len_sum;
  logic [LEN_W-1:0]         len2_r;
  logic signed [DOT_W-1:0]  dot_r;
  logic signed [DIFF_W-1:0] dx3_r, dy3_r, rx3_r, ry3_r;
  assign len_sum = DOT_W'(dxx_r) + DOT_W'(dyy_r);
  always_ff @(posedge clk) begin
    if (adv) begin
      len2_r <= len_sum[LEN_W-1:0];
      dot_r  <= DOT_W'(rdx_r) + DOT_W'(rdy_r);
      dx3_r  <= dx2_r;
      dy3_r  <= dy2_r;
      rx3_r  <= rx2_r;
      ry3_r  <= ry2_r;
    end
  end

  // A zero-length chord has a zero dot product, so it takes the start point
  // as its nearest point and the plain point distance results.
  proj_mode_t       mode;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  chord_side_t      side_r [DIV_LAT+1];
  always_comb begin
    if (dot_r <= 0) begin
      mode = PM_ZERO;
    end else if (dot_r >= $signed({1'b0, len2_r})) begin
      mode = PM_ONE;
    end else begin
      mode = PM_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r     <= (NUM_W'(dot_r) << T_W) + NUM_W'(len2_r);
      den_r     <= {len2_r, 1'b0};
      side_r[0] <= '{mode: mode, rx: rx3_r, ry: ry3_r, dx: dx3_r, dy: dy3_r};
      for (int s = 1; s <= DIV_LAT; s++) begin
        side_r[s] <= side_r[s-1];
      end
    end
  end

  logic [T_W-1:0] quo;
  cbp_div u_div (
    .clk (clk),
    .adv (adv),
    .num (num_r),
    .den (den_r),
    .quo (quo)
  );

  chord_side_t side_d;
  logic [T_W-1:0] t_par;
  assign side_d = side_r[DIV_LAT];
  always_comb begin
    case (side_d.mode)
      PM_ZERO: t_par = '0;
      PM_ONE:  t_par = T_ONE;
      PM_DIV:  t_par = quo;
      default: t_par = '0;
    endcase
  end

  logic signed [PT_W-1:0]   ptx_r, pty_r;
  logic signed [DIFF_W-1:0] rx4_r, ry4_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      ptx_r <= $signed({1'b0, t_par}) * side_d.dx;
      pty_r <= $signed({1'b0, t_par}) * side_d.dy;
      rx4_r <= side_d.rx;
      ry4_r <= side_d.ry;
    end
  end

  logic signed [PT_W-1:0]  ptx_rnd, pty_rnd;
  logic signed [OFF_W-1:0] ox_r, oy_r;
  assign ptx_rnd = ptx_r + PT_W'(32768);
  assign pty_rnd = pty_r + PT_W'(32768);
  always_ff @(posedge clk) begin
    if (adv) begin
      ox_r <= OFF_W'(rx4_r) - $signed(ptx_rnd[PT_W-1:FRAC_BITS]);
      oy_r <= OFF_W'(ry4_r) - $signed(pty_rnd[PT_W-1:FRAC_BITS]);
    end
  end

  logic signed [OSQ_W-1:0] oxx_r, oyy_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      oxx_r <= ox_r * ox_r;
      oyy_r <= oy_r * oy_r;
    end
  end

  logic [DIST_W-1:0] dist2;
  logic              hit_r;
  assign dist2 = DIST_W'(unsigned'(oxx_r)) + DIST_W'(unsigned'(oyy_r));
  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r <= dist2 <= DIST_W'(thr2);
    end
  end

  assign hit = hit_r;

endmodule

>>> rtl/cubic_bezier_point_proximity.sv
// Path: input registers, sampling stages, chord lanes, result register; one request per cycle.
// Throughput: one request every cycle; every lane, divider bit and multiplier has
// its own pipeline stage, so only a stalled result holds the pipe.
// Reset (rst_n low, synchronous) clears all valid bits and sets near_distance to 5.0.
// The threshold register may only be written while no request is in flight.
`timescale 1ns / 1ps
module cubic_bezier_point_proximity
  import cbp_pkg::*;
#(
  parameter int CHORD_COUNT = CHORD_COUNT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_query_x,
  input  logic signed [COORD_W-1:0] in_query_y,
  input  logic signed [COORD_W-1:0] in_start_x,
  input  logic signed [COORD_W-1:0] in_start_y,
  input  logic signed [COORD_W-1:0] in_ctrl_a_x,
  input  logic signed [COORD_W-1:0] in_ctrl_a_y,
  input  logic signed [COORD_W-1:0] in_ctrl_b_x,
  input  logic signed [COORD_W-1:0] in_ctrl_b_y,
  input  logic signed [COORD_W-1:0] in_finish_x,
  input  logic signed [COORD_W-1:0] in_finish_y,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_is_near,
  input  logic                      cfg_we,
  input  logic [NEAR_W-1:0]         cfg_wdata
);

  localparam int VLINE = SAMP_LAT + LANE_LAT;

  logic adv;
  logic out_valid_r, out_near_r;
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // Threshold register and its square.
  logic [NEAR_W-1:0] nd_r;
  logic [THR_W-1:0]  thr2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nd_r   <= NEAR_RESET;
      thr2_r <= THR_W'(NEAR_RESET) * THR_W'(NEAR_RESET);
    end else begin
      if (cfg_we) begin
        nd_r <= cfg_wdata;
      end
      thr2_r <= THR_W'(nd_r) * THR_W'(nd_r);
    end
  end

  logic signed [COORD_W-1:0] qx_r, qy_r;
  logic signed [COORD_W-1:0] px_r [4];
  logic signed [COORD_W-1:0] py_r [4];
  always_ff @(posedge clk) begin
    if (adv) begin
      qx_r    <= in_query_x;
      qy_r    <= in_query_y;
      px_r[0] <= in_start_x;
      py_r[0] <= in_start_y;
      px_r[1] <= in_ctrl_a_x;
      py_r[1] <= in_ctrl_a_y;
      px_r[2] <= in_ctrl_b_x;
      py_r[2] <= in_ctrl_b_y;
      px_r[3] <= in_finish_x;
      py_r[3] <= in_finish_y;
    end
  end

  logic              in_vld_r;
  logic [VLINE-1:0]  vline_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      vline_r  <= '0;
    end else if (adv) begin
      in_vld_r <= in_valid;
      vline_r  <= {vline_r[VLINE-2:0], in_vld_r};
    end
  end

  logic signed [COORD_W-1:0] sqx, sqy;
  logic signed [SAMP_W-1:0]  samp_x [CHORD_COUNT+1];
  logic signed [SAMP_W-1:0]  samp_y [CHORD_COUNT+1];

  cbp_sample #(
    .CHORD_COUNT (CHORD_COUNT)
  ) u_sample (
    .clk    (clk),
    .adv    (adv),
    .qx     (qx_r),
    .qy     (qy_r),
    .px     (px_r),
    .py     (py_r),
    .qx_o   (sqx),
    .qy_o   (sqy),
    .samp_x (samp_x),
    .samp_y (samp_y)
  );

  logic [CHORD_COUNT-1:0] hits;
  for (genvar c = 0; c < CHORD_COUNT; c++) begin : g_chord
    cbp_chord u_chord (
      .clk  (clk),
      .adv  (adv),
      .thr2 (thr2_r),
      .qx   (sqx),
      .qy   (sqy),
      .sx   (samp_x[c]),
      .sy   (samp_y[c]),
      .ex   (samp_x[c+1]),
      .ey   (samp_y[c+1]),
      .hit  (hits[c])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vline_r[VLINE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_near_r <= |hits;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_is_near = out_near_r;

`ifndef ASSERT_OFF
  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while the result is held");

  a_thr_square: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(cfg_we) |-> thr2_r == THR_W'(nd_r) * THR_W'(nd_r))
    else $error("threshold square out of step with near_distance");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_vld_r)
    else $error("valid bits survive reset");
`endif

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the cubic Bezier point proximity block.
`timescale 1ns / 1ps
module testbench;
  import cbp_pkg::*;

  class proximity_scoreboard;
    bit expected_near[$];
    int mismatches;

    function void note_request(bit near_flag);
      expected_near = {expected_near, near_flag};
    endfunction

    task check_result(bit got);
      bit want;
      if (expected_near.size() == 0) begin
        report_mismatch($sformatf("unexpected result is_near=%0d", got));
        return;
      end
      want = expected_near.pop_front();
      if (got !== want)
        report_mismatch($sformatf("is_near got %0d, expected %0d", got, want));
    endtask

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask
  endclass

  localparam int N_CHORDS = CHORD_COUNT_DEF;
  localparam int LATENCY = 28;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [COORD_W-1:0] f_qx = '0, f_qy = '0, f_sx = '0, f_sy = '0;
  logic signed [COORD_W-1:0] f_ax = '0, f_ay = '0, f_bx = '0, f_by = '0;
  logic signed [COORD_W-1:0] f_ex = '0, f_ey = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_is_near;
  logic cfg_we = 1'b0;
  logic [NEAR_W-1:0] cfg_wdata = '0;

  logic [NEAR_W-1:0] threshold = NEAR_RESET;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  longint cycles = 0;
  proximity_scoreboard sb = new();

  cubic_bezier_point_proximity DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_query_x(f_qx), .in_query_y(f_qy),
    .in_start_x(f_sx), .in_start_y(f_sy),
    .in_ctrl_a_x(f_ax), .in_ctrl_a_y(f_ay),
    .in_ctrl_b_x(f_bx), .in_ctrl_b_y(f_by),
    .in_finish_x(f_ex), .in_finish_y(f_ey),
    .out_valid(out_valid), .out_stall(out_stall), .out_is_near(out_is_near),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint floor_div_pow16(longint v);
    return v >>> 16;
  endfunction

  function automatic longint round_q16(longint v);
    return floor_div_pow16(v + 32768);
  endfunction

  function automatic longint bern_weight(longint num, longint den);
    return (num * 131072 + den) / (2 * den);
  endfunction

  function automatic bit chord_within(longint qx, longint qy, longint sx, longint sy,
                                      longint ex, longint ey, longint thr2);
    longint dx, dy, rx, ry, len2, dot, t, ox, oy;
    dx = ex - sx; dy = ey - sy;
    rx = qx - sx; ry = qy - sy;
    len2 = dx * dx + dy * dy;
    if (len2 == 0) return (rx * rx + ry * ry) <= thr2;
    dot = rx * dx + ry * dy;
    if (dot <= 0) t = 0;
    else if (dot >= len2) t = 65536;
    else t = (dot * 131072 + len2) / (2 * len2);
    ox = rx - round_q16(t * dx);
    oy = ry - round_q16(t * dy);
    return (ox * ox + oy * oy) <= thr2;
  endfunction

  function automatic bit predict_near(longint qx, longint qy, longint p1x, longint p1y,
                                      longint p2x, longint p2y, longint p3x, longint p3y,
                                      longint p4x, longint p4y);
    longint thr2, n3, px, py, k, w1, w2, w3, w4, cx, cy;
    thr2 = longint'(threshold) * longint'(threshold);
    n3 = N_CHORDS * N_CHORDS * N_CHORDS;
    px = p1x; py = p1y;
    for (int i = 1; i <= N_CHORDS; i++) begin
      k = N_CHORDS - i;
      w1 = bern_weight(k * k * k, n3);
      w2 = bern_weight(3 * k * k * i, n3);
      w3 = bern_weight(3 * k * i * i, n3);
      w4 = bern_weight(i * i * i, n3);
      cx = round_q16(w1 * p1x + w2 * p2x + w3 * p3x + w4 * p4x);
      cy = round_q16(w1 * p1y + w2 * p2y + w3 * p3y + w4 * p4y);
      if (chord_within(qx, qy, px, py, cx, cy, thr2)) return 1'b1;
      px = cx; py = cy;
    end
    return 1'b0;
  endfunction

  // Receiver side: random stall, checks every accepted result.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) sb.check_result(out_is_near);
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_request(input logic signed [COORD_W-1:0] c[10]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    f_qx <= c[0]; f_qy <= c[1]; f_sx <= c[2]; f_sy <= c[3];
    f_ax <= c[4]; f_ay <= c[5]; f_bx <= c[6]; f_by <= c[7];
    f_ex <= c[8]; f_ey <= c[9];
    sb.note_request(predict_near(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7],
                                 c[8], c[9]));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (sb.expected_near.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [NEAR_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    threshold = value;
  endtask

  // Random curve with a query point placed near a control point, so hits are common.
  task automatic send_random(input int span);
    logic signed [COORD_W-1:0] c[10];
    int pick;
    for (int j = 2; j < 10; j++) c[j] = COORD_W'($urandom);
    if (span < 32768)
      for (int j = 2; j < 10; j++)
        c[j] = COORD_W'($signed($urandom_range(2 * span)) - span);
    pick = $urandom_range(4);
    if (pick == 4 || $urandom_range(9) == 0) begin
      c[0] = COORD_W'($urandom); c[1] = COORD_W'($urandom);
    end else begin
      c[0] = c[2 + 2 * pick] + COORD_W'($signed($urandom_range(400)) - 200);
      c[1] = c[3 + 2 * pick] + COORD_W'($signed($urandom_range(400)) - 200);
    end
    send_request(c);
  endtask

  initial begin
    logic signed [COORD_W-1:0] c[10];
    logic signed [COORD_W-1:0] lo, hi;
    lo = -16'sd32768; hi = 16'sd32767;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset threshold, extremes, degenerate curve, exact hit.
    c = '{lo, lo, lo, lo, hi, hi, lo, hi, hi, lo}; send_request(c);
    c = '{hi, hi, lo, lo, lo, lo, lo, lo, lo, lo}; send_request(c);
    c = '{lo, lo, lo, lo, lo, lo, lo, lo, lo, lo}; send_request(c);
    c = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0}; send_request(c);
    c = '{81, 0, 0, 0, 0, 0, 0, 0, 0, 0}; send_request(c);
    c = '{80, 0, 0, 0, 0, 0, 0, 0, 0, 0}; send_request(c);
    c = '{100, 80, 0, 0, 64, 0, 128, 0, 200, 0}; send_request(c);
    c = '{100, 81, 0, 0, 64, 0, 128, 0, 200, 0}; send_request(c);
    c = '{hi, lo, hi, hi, lo, lo, hi, lo, lo, hi}; send_request(c);
    c = '{-5, 3, -1, 2, hi, lo, lo, hi, 3, 7}; send_request(c);
    drain();
    write_threshold('0);
    c = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0}; send_request(c);
    c = '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0}; send_request(c);
    c = '{160, 0, 0, 0, 100, 0, 200, 0, 320, 0}; send_request(c);
    drain();
    write_threshold(12'hFFF);
    c = '{lo, lo, hi, hi, hi, hi, hi, hi, hi, hi}; send_request(c);
    c = '{0, 0, 4000, 4000, 4000, 4000, 4000, 4000, 4000, 4000}; send_request(c);
    c = '{0, 0, 2900, 2900, 2900, 2900, 2900, 2900, 2900, 2900}; send_request(c);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 67 : 0;
      recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 30 : 0;
      for (int s = 0; s < 4; s++) begin
        write_threshold(s == 0 ? NEAR_W'($urandom) : NEAR_W'($urandom_range(200)));
        for (int n = 0; n < 80; n++)
          send_random(($urandom_range(19) == 0) ? 32768 : $urandom_range(30, 3000));
        // Let the pipe empty completely before the next threshold.
        drain();
      end
    end

    drain();
    if (sb.mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

>>> cubic_bezier_point_proximity.f
rtl/cbp_pkg.sv
rtl/cbp_sample.sv
rtl/cbp_div.sv
rtl/cbp_chord.sv
rtl/cubic_bezier_point_proximity.sv
tb/testbench.sv
